// File: hw/rtl/tpc_pkg.sv
// Shared constants for the tree pseudo-LRU tag cache.
`default_nettype none
package tpc_pkg;

	localparam int unsigned DEFAULT_LINE_COUNT = 16;
	localparam int unsigned DEFAULT_TAG_WIDTH  = 32;

	localparam int unsigned REQ_WIDTH   = 32;
	localparam int unsigned LIMIT_WIDTH = 32;
	localparam int unsigned IDX_WIDTH   = 4;

	localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = '1;

endpackage
`default_nettype wire

// File: hw/rtl/tree_plru_tag_cache.sv
// Fully associative tag store with tree pseudo-LRU replacement.
//
//  channel | direction | handshake          | beat
//  --------+-----------+--------------------+------------------------------------------
//  in      | to block  | in_valid/in_stall  | request_tag
//  out     | from block| out_valid/out_stall| hit, line_index, evicted_valid/tag, out_of_range
//  cfg     | to block  | cfg_valid/cfg_ready| cfg_data -> block_limit
//
// One request per cycle unless the result stalls. A request passes the request register, then
// tag match, victim walk and tree update in one pass into the result register.
// Reset clears valid bits, tree bits and handshake state; block_limit returns
// to all ones. Tags are not reset. A stalled result holds the result register,
// and the request register stalls only when it is full behind it.
`default_nettype none
module tree_plru_tag_cache
	import tpc_pkg::*;
#(
	parameter int unsigned LINE_COUNT = DEFAULT_LINE_COUNT,
	parameter int unsigned TAG_WIDTH  = DEFAULT_TAG_WIDTH
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,

	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [REQ_WIDTH-1:0]   request_tag,

	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic                        hit,
	output logic [IDX_WIDTH-1:0]        line_index,
	output logic                        evicted_valid,
	output logic [REQ_WIDTH-1:0]        evicted_tag,
	output logic                        out_of_range,

	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [LIMIT_WIDTH-1:0] cfg_data
);

	localparam int unsigned LVL   = $clog2(LINE_COUNT);
	localparam int unsigned NODES = (2 ** LVL) - 1;
	localparam int unsigned NW    = LVL;

	logic [LIMIT_WIDTH-1:0] block_limit_q;

	logic                   valid_s1;
	logic [REQ_WIDTH-1:0]   req_s1;

	logic                   out_valid_q;
	logic                   hit_s2;
	logic [IDX_WIDTH-1:0]   idx_s2;
	logic                   ev_valid_s2;
	logic [REQ_WIDTH-1:0]   ev_tag_s2;
	logic                   oor_s2;

	logic [LINE_COUNT-1:0]  line_valid_q;
	logic [TAG_WIDTH-1:0]   line_tag_q [LINE_COUNT];
	logic [NODES-1:0]       plru_q;

	logic                   adv;
	logic                   fire;

	logic [TAG_WIDTH-1:0]   tag_s1;
	logic                   oor;
	logic [LINE_COUNT-1:0]  match;
	logic                   hit_any;
	logic [LVL-1:0]         hit_idx;
	logic [LVL-1:0]         victim;
	logic [NODES-1:0]       plru_hit;
	logic [NODES-1:0]       plru_miss;
	logic [LVL:0]           node_v;
	logic [LVL:0]           nidx;
	logic [LVL:0]           leaf_ext;
	logic [LVL-1:0]         res_idx;

	assign cfg_ready = 1'b1;

	assign adv      = !(out_valid_q && out_stall);
	assign fire     = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;

	// Tag match and hit-path update
	always_comb begin
		tag_s1 = TAG_WIDTH'(req_s1);
		oor    = (req_s1 >= block_limit_q);
		for (int i = 0; i < LINE_COUNT; i++) begin
			match[i] = line_valid_q[i] && (line_tag_q[i] == tag_s1);
		end
		hit_any = |match;
		hit_idx = '0;
		for (int i = LINE_COUNT - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_idx = LVL'(i);
			end
		end
		plru_hit = plru_q;
		for (int k = 0; k < LVL; k++) begin
			nidx = (LVL+1)'((2 ** k) - 1) + (LVL+1)'(hit_idx >> (LVL - k));
			plru_hit[nidx[NW-1:0]] = ~hit_idx[LVL-1-k];
		end
	end

	// Victim walk, toggling every bit passed
	always_comb begin
		plru_miss = plru_q;
		node_v    = '0;
		for (int k = 0; k < LVL; k++) begin
			plru_miss[node_v[NW-1:0]] = ~plru_q[node_v[NW-1:0]];
			node_v = (node_v << 1) + (LVL+1)'(1) + (LVL+1)'(plru_q[node_v[NW-1:0]]);
		end
		leaf_ext = node_v - (LVL+1)'(NODES);
		if (leaf_ext >= (LVL+1)'(LINE_COUNT)) begin
			victim = LVL'(leaf_ext - (LVL+1)'(LINE_COUNT));
		end else begin
			victim = leaf_ext[LVL-1:0];
		end
		res_idx = hit_any ? hit_idx : victim;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			block_limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
			line_valid_q <= '0;
			plru_q       <= '0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				out_valid_q <= valid_s1;
			end
			if (fire && !oor) begin
				plru_q <= hit_any ? plru_hit : plru_miss;
				if (!hit_any) begin
					line_valid_q[victim] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			req_s1 <= request_tag;
		end
		if (fire && !oor && !hit_any) begin
			line_tag_q[victim] <= tag_s1;
		end
		if (fire) begin
			if (oor) begin
				hit_s2      <= 1'b0;
				idx_s2      <= '0;
				ev_valid_s2 <= 1'b0;
				ev_tag_s2   <= '0;
				oor_s2      <= 1'b1;
			end else begin
				hit_s2      <= hit_any;
				idx_s2      <= IDX_WIDTH'(res_idx);
				ev_valid_s2 <= !hit_any && line_valid_q[victim];
				ev_tag_s2   <= (!hit_any && line_valid_q[victim]) ?
					REQ_WIDTH'(line_tag_q[victim]) : '0;
				oor_s2      <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_s2;
	assign line_index    = idx_s2;
	assign evicted_valid = ev_valid_s2;
	assign evicted_tag   = ev_tag_s2;
	assign out_of_range  = oor_s2;

endmodule
`default_nettype wire

// File: hw/rtl/tpc_checker.sv
// Port-level checks for the tree pseudo-LRU tag cache, with bind.
`default_nettype none
module tpc_checker
	import tpc_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_stall,
	input wire logic [REQ_WIDTH-1:0]   request_tag,
	input wire logic                   out_valid,
	input wire logic                   out_stall,
	input wire logic                   hit,
	input wire logic [IDX_WIDTH-1:0]   line_index,
	input wire logic                   evicted_valid,
	input wire logic [REQ_WIDTH-1:0]   evicted_tag,
	input wire logic                   out_of_range,
	input wire logic                   cfg_valid,
	input wire logic                   cfg_ready,
	input wire logic [LIMIT_WIDTH-1:0] cfg_data
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit) && $stable(line_index)
			&& $stable(evicted_valid) && $stable(evicted_tag) && $stable(out_of_range))
		else $error("result beat changed under stall");

	// input backs up only behind a stalled result
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output stall");

	// accepted request shows a result after the request and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> ##2 out_valid)
		else $error("result missing after accepted request");

	// no eviction on hit or flagged request
	a_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (hit || out_of_range) |-> !evicted_valid && evicted_tag == '0
			&& !(hit && out_of_range))
		else $error("eviction reported on hit or flagged request");

endmodule

bind tree_plru_tag_cache tpc_checker u_tpc_checker (.*);
`default_nettype wire

// File: tb/tree_plru_tag_cache_tb.sv
// Self-checking testbench for the tree pseudo-LRU tag cache: directed rows, then random lookups.
`timescale 1ns / 100ps
`default_nettype none
module tree_plru_tag_cache_tb;
	import tpc_pkg::*;

	localparam int unsigned LINES  = DEFAULT_LINE_COUNT;
	localparam int unsigned LEVELS = IDX_WIDTH;
	localparam int unsigned INNER  = LINES - 1;
	localparam int unsigned PHASE_ITEMS = 275;

	typedef struct packed {
		logic                 hit;
		logic [IDX_WIDTH-1:0] line;
		logic                 ev_valid;
		logic [REQ_WIDTH-1:0] ev_tag;
		logic                 oor;
	} lookup_res_t;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		logic [REQ_WIDTH-1:0] value;
		logic                 typed;
		lookup_res_t          want;
	} dir_row_t;

	localparam lookup_res_t NO_RES  = '{1'b0, '0, 1'b0, '0, 1'b0};
	localparam lookup_res_t OOR_RES = '{1'b0, '0, 1'b0, '0, 1'b1};

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic [REQ_WIDTH-1:0]   request_tag;
	logic                   out_valid;
	logic                   out_stall;
	logic                   hit;
	logic [IDX_WIDTH-1:0]   line_index;
	logic                   evicted_valid;
	logic [REQ_WIDTH-1:0]   evicted_tag;
	logic                   out_of_range;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [LIMIT_WIDTH-1:0] cfg_data;

	tree_plru_tag_cache u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.request_tag   (request_tag),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.hit           (hit),
		.line_index    (line_index),
		.evicted_valid (evicted_valid),
		.evicted_tag   (evicted_tag),
		.out_of_range  (out_of_range),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	// shadow cache state
	bit                     shadow_valid [LINES];
	logic [REQ_WIDTH-1:0]   shadow_tag   [LINES];
	bit                     shadow_tree  [INNER];
	logic [LIMIT_WIDTH-1:0] shadow_limit;

	lookup_res_t pending_results [$];
	int          mismatch_count;
	bit          quiet;
	bit          hold_req;
	bit          hold_done;

	dir_row_t dir_rows [27] = '{
		'{ROW_CFG, 32'hFFFF_FFFF, 1'b0, NO_RES},
		'{ROW_REQ, 32'h0000_0005, 1'b1, NO_RES},
		'{ROW_REQ, 32'hFFFF_FFFF, 1'b1, OOR_RES},
		'{ROW_REQ, 32'h0000_0000, 1'b0, NO_RES},
		'{ROW_REQ, 32'hFFFF_FFFE, 1'b0, NO_RES},
		'{ROW_REQ, 32'h0000_0005, 1'b0, NO_RES},
		'{ROW_REQ, 32'hAAAA_AAAA, 1'b0, NO_RES},
		'{ROW_REQ, 32'h5555_5555, 1'b0, NO_RES},
		'{ROW_REQ, 32'h0000_0010, 1'b0, NO_RES},
		'{ROW_REQ, 32'h0000_0011, 1'b0, NO_RES},
		'{ROW_REQ, 32'h0000_0012, 1'b0, NO_RES},
		'{ROW_REQ, 32'h0000_0013, 1'b0, NO_RES},
		'{ROW_REQ, 32'h0000_0014, 1'b0, NO_RES},
		'{ROW_REQ, 32'h0000_0015, 1'b0, NO_RES},
		'{ROW_REQ, 32'h0000_0016, 1'b0, NO_RES},
		'{ROW_REQ, 32'h0000_0017, 1'b0, NO_RES},
		'{ROW_REQ, 32'h0000_0018, 1'b0, NO_RES},
		'{ROW_REQ, 32'h0000_0019, 1'b0, NO_RES},
		'{ROW_REQ, 32'h0000_0020, 1'b0, NO_RES},
		'{ROW_REQ, 32'h0000_0021, 1'b0, NO_RES},
		'{ROW_REQ, 32'h0000_0000, 1'b0, NO_RES},
		'{ROW_CFG, 32'h0000_0000, 1'b0, NO_RES},
		'{ROW_REQ, 32'h0000_0000, 1'b1, OOR_RES},
		'{ROW_REQ, 32'h7FFF_FFFF, 1'b1, OOR_RES},
		'{ROW_CFG, 32'h0000_0001, 1'b0, NO_RES},
		'{ROW_REQ, 32'h0000_0000, 1'b0, NO_RES},
		'{ROW_REQ, 32'h0000_0001, 1'b1, OOR_RES}
	};

	logic [LIMIT_WIDTH-1:0] phase_limits [5] = '{
		LIMIT_RESET, 32'd1, 32'd300, 32'h8000_0000, LIMIT_RESET
	};

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic lookup_res_t cache_lookup(input logic [REQ_WIDTH-1:0] tag);
		lookup_res_t res;
		int found;
		int unsigned node;
		int unsigned parent;
		int unsigned ln;
		bit b;
		res = NO_RES;
		found = -1;
		if (tag >= shadow_limit) begin
			res.oor = 1'b1;
			return res;
		end
		for (int i = 0; i < LINES; i++) begin
			if (found < 0 && shadow_valid[i] && shadow_tag[i] == tag)
				found = i;
		end
		if (found >= 0) begin
			node = found + INNER;
			while (node != 0) begin
				parent = (node - 1) / 2;
				shadow_tree[parent] = (node == 2 * parent + 1);
				node = parent;
			end
			res.hit = 1'b1;
			res.line = found[IDX_WIDTH-1:0];
			return res;
		end
		node = 0;
		for (int l = 0; l < LEVELS; l++) begin
			b = shadow_tree[node];
			shadow_tree[node] = ~b;
			node = 2 * node + 1 + b;
		end
		ln = node - INNER;
		if (shadow_valid[ln]) begin
			res.ev_valid = 1'b1;
			res.ev_tag = shadow_tag[ln];
		end
		shadow_valid[ln] = 1'b1;
		shadow_tag[ln] = tag;
		res.line = ln[IDX_WIDTH-1:0];
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || (hold_req && !hold_done) || r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 30);
	endfunction

	task automatic send_request(input logic [REQ_WIDTH-1:0] tag, input bit typed,
			input lookup_res_t typed_want);
		int gap;
		lookup_res_t res;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		request_tag <= tag;
		do @(posedge clk); while (in_stall);
		res = cache_lookup(tag);
		pending_results.push_back(typed ? typed_want : res);
	endtask

	task automatic write_limit(input logic [LIMIT_WIDTH-1:0] value);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		shadow_limit = value;
	endtask

	// fields: hit/line/evicted_valid/evicted_tag/out_of_range
	task automatic report_mismatch(input string what, input lookup_res_t want,
			input lookup_res_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t %s: want %0d/%0d/%0d/%h/%0d, got %0d/%0d/%0d/%h/%0d",
				$realtime, what, want.hit, want.line, want.ev_valid, want.ev_tag, want.oor,
				got.hit, got.line, got.ev_valid, got.ev_tag, got.oor);
	endtask

	always @(posedge clk) begin
		lookup_res_t got;
		lookup_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{hit, line_index, evicted_valid, evicted_tag, out_of_range};
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected beat", NO_RES, got);
			end else begin
				want = pending_results.pop_front();
				if (got !== want)
					report_mismatch("result mismatch", want, got);
			end
		end
	end

	// receiver side: random stalls, plus one long hold-off on request
	initial begin
		int r;
		hold_done = 1'b0;
		out_stall <= 1'b0;
		forever begin
			if (hold_req && !hold_done) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				hold_done = 1'b1;
			end else if (quiet) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 45) begin
					out_stall <= 1'b0;
					repeat ($urandom_range(1, 12)) @(posedge clk);
				end else if (r < 90) begin
					out_stall <= 1'b1;
					repeat ($urandom_range(1, 3)) @(posedge clk);
				end else begin
					out_stall <= 1'b1;
					repeat ($urandom_range(10, 40)) @(posedge clk);
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("tree_plru_tag_cache_tb: errors");
		$finish;
	end

	initial begin
		logic [REQ_WIDTH-1:0] pool_base;
		logic [REQ_WIDTH-1:0] tag;
		logic [LIMIT_WIDTH-1:0] lim;
		int r;
		mismatch_count = 0;
		quiet = 1'b0;
		hold_req = 1'b0;
		for (int i = 0; i < LINES; i++) begin
			shadow_valid[i] = 1'b0;
			shadow_tag[i] = '0;
		end
		for (int i = 0; i < INNER; i++)
			shadow_tree[i] = 1'b0;
		shadow_limit = LIMIT_RESET;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		request_tag <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG)
				write_limit(dir_rows[i].value);
			else
				send_request(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);
		end

		foreach (phase_limits[p]) begin
			lim = phase_limits[p];
			write_limit(lim);
			quiet = (p == 3);
			if (p == 2)
				hold_req = 1'b1;
			pool_base = (lim > 64) ? $urandom_range(0, lim - 64) : '0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(0, 99);
				if (r < 60)
					tag = pool_base + $urandom_range(0, 23);
				else if (r < 75)
					tag = lim + $urandom_range(0, 2) - 1;
				else
					tag = $urandom;
				send_request(tag, 1'b0, NO_RES);
			end
			quiet = 1'b0;
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("tree_plru_tag_cache_tb: clean");
		else
			$display("tree_plru_tag_cache_tb: errors");
		$finish;
	end

endmodule
`default_nettype wire
